FILE: hw/rtl/tcw_pkg.sv
// ============================================================================
// tcw_pkg: shared types and constants of the text console writer
// Field widths, character codes, register map, controller states and the
// screen cell packing helper.
// ============================================================================
package tcw_pkg;

  // Fixed field widths of the item and result channels
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int CURSOR_W = 11;
  localparam int INDEX_W  = 11;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_TEXT_COLOR = 1'b0;  // word index, taken from paddr[2]

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7F;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  // Item commands
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Controller states
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_TAB    = 5'b00100,
    S_SCROLL = 5'b01000,
    S_EMIT   = 5'b10000
  } tcw_state_t;

  // Pack a character and attribute into one screen cell
  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                   input logic [ATTR_W-1:0] attr);
    make_cell = {attr, ch};
  endfunction

endpackage

FILE: hw/rtl/tcw_screen_mem.sv
// ============================================================================
// tcw_screen_mem: screen cell store
// One write port and one read port, read data registered.
// ============================================================================
module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  // Write cells
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read cells, hold the data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/tcw_mod_unit.sv
// ============================================================================
// tcw_mod_unit: remainder by a constant divisor
// Reciprocal multiplication: quotient registered when start is taken,
// remainder and done registered the cycle after that.
// ============================================================================
module tcw_mod_unit #(
  parameter int DIV_W   = 12,
  parameter int DIVISOR = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [DIV_W-1:0]             dividend,
  output logic                         done,
  output logic [$clog2(DIVISOR)-1:0]   rem
);
  import tcw_pkg::*;

  localparam int RW    = $clog2(DIVISOR);
  localparam int MW    = DIV_W + 1;
  localparam int PW    = DIV_W + MW;
  localparam int SHIFT = DIV_W + RW;
  localparam int QW    = PW - SHIFT;
  // Rounded-up reciprocal, exact for every dividend below 2**DIV_W
  localparam longint MAGIC = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                             / longint'(DIVISOR);

  logic             stage_r;
  logic             done_r;
  logic [DIV_W-1:0] x_r;
  logic [QW-1:0]    q_r;
  logic [RW-1:0]    rem_r;
  logic [PW-1:0]    prod;
  logic [DIV_W-1:0] qd;
  logic [DIV_W-1:0] diff;

  // Quotient by reciprocal, then the remainder from it
  assign prod = PW'(dividend) * PW'(MAGIC);
  assign qd   = DIV_W'(q_r) * DIV_W'(DIVISOR);
  assign diff = x_r - qd;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start;
      done_r  <= stage_r;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= dividend;
      q_r <= prod[PW-1:SHIFT];
    end
    if (stage_r) begin
      rem_r <= diff[RW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_no_restart_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r |-> !start) else $error("remainder unit restarted while busy");

endmodule

FILE: hw/rtl/tcw_cfg_regs.sv
// ============================================================================
// tcw_cfg_regs: configuration register block
// APB-style port holding the text attribute register.
// ============================================================================
module tcw_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcw_pkg::APB_AW-1:0] paddr,
  input  logic [tcw_pkg::APB_DW-1:0] pwdata,
  output logic [tcw_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [tcw_pkg::ATTR_W-1:0] text_color
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] text_color_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the attribute register; byte-lane bits of the address are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_ATTR;
    end else if (wr_en && (paddr[2] == REG_TEXT_COLOR)) begin
      text_color_r <= pwdata[ATTR_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TEXT_COLOR) begin
      prdata = APB_DW'(text_color_r);
    end
  end

  assign text_color = text_color_r;

endmodule

FILE: hw/rtl/text_console_char_writer.sv
// ============================================================================
// text_console_char_writer: text console character writer
// Screen store of character/attribute cells with a linear cursor, put and
// read items, and scrolling when the cursor runs off the screen.
// ============================================================================
// After reset the block clears the screen store to spaces with attribute 0x0F,
// one cell per cycle, before it accepts its first item; configuration writes
// are taken meanwhile. A read item or a put of any code other than tab is
// accepted in the idle state and its result loaded from the emit state. A tab
// first passes a remainder unit that finds the cursor's offset from the last
// tab stop by reciprocal multiplication. A put that runs the cursor off the
// screen adds scroll steps, each bound by the single write port of the screen
// store, through which every cell is copied one row up and the bottom row
// refilled. A result may wait at the output while the next item is accepted.
// ============================================================================
module text_console_char_writer #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Item channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]  in_cell_index,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tcw_pkg::CURSOR_W-1:0] out_cursor_pos,
  output logic [tcw_pkg::CHAR_W-1:0]   out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]   out_cell_attr,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]   paddr,
  input  logic [tcw_pkg::APB_DW-1:0]   pwdata,
  output logic [tcw_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + COLUMNS + TAB_WIDTH);
  localparam int COLW  = $clog2(COLUMNS);
  localparam int SCW   = $clog2(CELLS + 1);
  localparam int RW    = $clog2(TAB_WIDTH);
  localparam int DW    = $clog2(TAB_WIDTH + 1);
  localparam int SW    = $clog2(COLUMNS + TAB_WIDTH);
  localparam int XW    = (CW > INDEX_W) ? CW : INDEX_W;

  tcw_state_t state_r, state_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [SCW-1:0]  s_cnt_r, s_cnt_nxt;
  logic            read_hit_r, read_hit_nxt;

  logic                out_valid_r;
  logic [CURSOR_W-1:0] out_cursor_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic [ATTR_W-1:0]   out_attr_r;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;

  logic          mod_start, mod_done;
  logic [RW-1:0] mod_rem;

  logic [ATTR_W-1:0] text_color;

  logic          in_fire, out_free, emit;
  logic          is_print, col_last;
  logic [XW-1:0] idx_ext, pos_ext;
  logic [DW-1:0] tab_delta;
  logic [SW-1:0] col_sum, col_sum1, col_sum2;
  logic [SCW-1:0] scr_raddr, scr_waddr;

  // Configuration registers
  tcw_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .text_color (text_color)
  );

  // Screen store
  tcw_screen_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Cursor remainder for tab stops
  tcw_mod_unit #(.DIV_W(CW), .DIVISOR(TAB_WIDTH)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (pos_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Handshake
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = (state_r == S_EMIT) && out_free;

  assign is_print = (in_char_code >= PRINT_LO) && (in_char_code <= PRINT_HI);
  assign col_last = (col_r == COLW'(COLUMNS - 1));
  assign idx_ext  = XW'(in_cell_index);
  assign pos_ext  = XW'(pos_r);

  // Tab: distance to the next stop and the wrapped column
  assign tab_delta = DW'(TAB_WIDTH) - DW'(mod_rem);
  assign col_sum   = SW'(col_r) + SW'(tab_delta);
  assign col_sum1  = (col_sum >= SW'(COLUMNS)) ? col_sum - SW'(COLUMNS) : col_sum;
  assign col_sum2  = (col_sum1 >= SW'(COLUMNS)) ? col_sum1 - SW'(COLUMNS) : col_sum1;

  // Scroll walk: read one row ahead, write the cell read in the previous step.
  // Reads always target cells at higher addresses than every write so far, so no forwarding is needed.
  assign scr_raddr = s_cnt_r + SCW'(COLUMNS);
  assign scr_waddr = s_cnt_r - SCW'(1);

  // Controller
  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    col_nxt      = col_r;
    s_cnt_nxt    = s_cnt_r;
    read_hit_nxt = read_hit_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    mod_start    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = s_cnt_r[AW-1:0];
        mem_wdata = make_cell(SPACE_CODE, RESET_ATTR);
        if (s_cnt_r == SCW'(CELLS - 1)) begin
          s_cnt_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          s_cnt_nxt = s_cnt_r + SCW'(1);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          read_hit_nxt = 1'b0;
          if (in_command == CMD_READ) begin
            // Read one cell; out-of-range reads return zero
            if (idx_ext < XW'(CELLS)) begin
              mem_re       = 1'b1;
              mem_raddr    = idx_ext[AW-1:0];
              read_hit_nxt = 1'b1;
            end
            state_nxt = S_EMIT;
          end else begin
            case (in_char_code)
              CODE_BS: begin
                if (pos_r != '0) begin
                  pos_nxt = pos_r - CW'(1);
                  col_nxt = (col_r == '0) ? COLW'(COLUMNS - 1) : col_r - COLW'(1);
                end
              end
              CODE_TAB: begin
                mod_start = 1'b1;
              end
              CODE_CR: begin
                pos_nxt = pos_r - CW'(col_r);
                col_nxt = '0;
              end
              CODE_LF: begin
                pos_nxt = pos_r + CW'(COLUMNS) - CW'(col_r);
                col_nxt = '0;
              end
              default: begin
                if (is_print) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_r[AW-1:0];
                  mem_wdata = make_cell(in_char_code, text_color);
                  pos_nxt   = pos_r + CW'(1);
                  col_nxt   = col_last ? '0 : col_r + COLW'(1);
                end
              end
            endcase
            if (in_char_code == CODE_TAB) begin
              state_nxt = S_TAB;
            end else if (pos_nxt >= CW'(CELLS)) begin
              s_cnt_nxt = '0;
              state_nxt = S_SCROLL;
            end else begin
              state_nxt = S_EMIT;
            end
          end
        end
      end

      S_TAB: begin
        if (mod_done) begin
          pos_nxt = pos_r + CW'(tab_delta);
          col_nxt = col_sum2[COLW-1:0];
          if (pos_nxt >= CW'(CELLS)) begin
            s_cnt_nxt = '0;
            state_nxt = S_SCROLL;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_SCROLL: begin
        // Fetch the cell one row below the write point
        if (s_cnt_r < SCW'(CELLS - COLUMNS)) begin
          mem_re    = 1'b1;
          mem_raddr = scr_raddr[AW-1:0];
        end
        // Copy it up, or fill the bottom row with blanks
        if (s_cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = scr_waddr[AW-1:0];
          mem_wdata = (scr_waddr < SCW'(CELLS - COLUMNS)) ? mem_rdata
                                                          : make_cell(SPACE_CODE, text_color);
        end
        if (s_cnt_r == SCW'(CELLS)) begin
          pos_nxt   = pos_r - CW'(COLUMNS);
          s_cnt_nxt = '0;
          state_nxt = (pos_nxt >= CW'(CELLS)) ? S_SCROLL : S_EMIT;
        end else begin
          s_cnt_nxt = s_cnt_r + SCW'(1);
        end
      end

      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      pos_r      <= '0;
      col_r      <= '0;
      s_cnt_r    <= '0;
      read_hit_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      col_r      <= col_nxt;
      s_cnt_r    <= s_cnt_nxt;
      read_hit_r <= read_hit_nxt;
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cursor_r <= pos_ext[CURSOR_W-1:0];
      out_char_r   <= read_hit_r ? mem_rdata[CHAR_W-1:0] : '0;
      out_attr_r   <= read_hit_r ? mem_rdata[CELL_W-1:CHAR_W] : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_cursor_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;

  // Checks
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pos_r < CW'(CELLS)))
    else $error("cursor off screen while idle");

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(col_r) < SW'(COLUMNS))
    else $error("column past end of row");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while previous item still in work");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside emit");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && !in_fire) |-> !mem_we)
    else $error("screen store written without an item");

endmodule

FILE: test/console_checker.sv
// ============================================================================
// console_checker: result checker for the text console character writer
// Watches the item, result and register ports, keeps its own screen, cursor
// and text colour, predicts one result per accepted item and compares each
// accepted result with the oldest prediction, field by field.
// ============================================================================
module console_checker #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_command,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]  in_cell_index,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [tcw_pkg::CURSOR_W-1:0] out_cursor_pos,
  input  logic [tcw_pkg::CHAR_W-1:0]   out_cell_char,
  input  logic [tcw_pkg::ATTR_W-1:0]   out_cell_attr,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]   paddr,
  input  logic [tcw_pkg::APB_DW-1:0]   pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           outstanding
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   ch;
    logic [ATTR_W-1:0]   attr;
  } console_reply_t;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cursor;
  logic [ATTR_W-1:0] text_color;
  console_reply_t    replies_due [$];
  int                fails = 0;

  // Apply one item to the screen copy and work out the result it gives
  function automatic console_reply_t predict_reply(input logic cmd,
                                                   input logic [CHAR_W-1:0] code,
                                                   input logic [INDEX_W-1:0] idx);
    console_reply_t r;
    int unsigned    i;
    r = '0;
    if (cmd == CMD_PUT) begin
      if (code == CODE_BS) begin
        // clamp at the top-left cell
        if (cursor > 0) cursor = cursor - 1;
      end else if (code == CODE_TAB) begin
        cursor = cursor + TAB_WIDTH - (cursor % TAB_WIDTH);
      end else if (code == CODE_CR) begin
        cursor = cursor - (cursor % COLUMNS);
      end else if (code == CODE_LF) begin
        cursor = cursor + COLUMNS - (cursor % COLUMNS);
      end else if (code >= PRINT_LO && code <= PRINT_HI) begin
        if (cursor < CELLS) screen[cursor] = {text_color, code};
        cursor = cursor + 1;
      end
      // scroll one row up per step and blank the bottom row
      while (cursor >= CELLS) begin
        for (i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {text_color, SPACE_CODE};
        cursor = cursor - COLUMNS;
      end
    end else if (idx < CELLS) begin
      {r.attr, r.ch} = screen[idx];
    end
    r.cursor = CURSOR_W'(cursor);
    return r;
  endfunction

  always @(posedge clk) begin
    console_reply_t got;
    console_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, SPACE_CODE};
      cursor     = 0;
      text_color = RESET_ATTR;
      replies_due.delete();
    end else begin
      // take register writes
      if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_COLOR)
        text_color = pwdata[ATTR_W-1:0];

      // compare the accepted result with the oldest prediction
      if (out_valid && out_ready) begin
        got = '{out_cursor_pos, out_cell_char, out_cell_attr};
        if (replies_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with nothing due: cursor %0d char %h attr %h",
                     $realtime, got.cursor, got.ch, got.attr);
        end else begin
          want = replies_due.pop_front();
          if (got.cursor != want.cursor || got.ch != want.ch || got.attr != want.attr) begin
            fails++;
            if (fails <= 10)
              $display("%0t: result mismatch: cursor %0d/%0d char %h/%h attr %h/%h (exp/got)",
                       $realtime, want.cursor, got.cursor, want.ch, got.ch,
                       want.attr, got.attr);
          end
        end
      end

      // predict the result of the accepted item
      if (in_valid && in_ready)
        replies_due.push_back(predict_reply(in_command, in_char_code, in_cell_index));
    end
    fail_count  <= fails;
    outstanding <= replies_due.size();
  end

endmodule

FILE: test/tb_top.sv
// ============================================================================
// tb_top: testbench of the text console character writer
// Drives directed and random put and read items in bursts, stalls the result
// side at random and twice for a long stretch, rewrites the text colour
// between phases and reports the verdict of the console checker.
// ============================================================================
module tb_top;
  import tcw_pkg::*;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int TAB_WIDTH     = 8;
  localparam int CELLS         = COLUMNS * ROWS;
  localparam int RANDOM_ITEMS  = 900;
  localparam int PHASES        = 5;
  localparam int MAX_ITEMS     = RANDOM_ITEMS + 32;
  localparam int HOLD_CYCLES   = 700;
  localparam int SETTLE_CYCLES = CELLS + COLUMNS + 64;
  localparam int CYCLE_LIMIT   = 4 * (CELLS + MAX_ITEMS * (2 * (CELLS + 1) + 64)
                                      + 2 * HOLD_CYCLES + (PHASES + 2) * SETTLE_CYCLES);
  localparam logic [APB_AW-1:0] TEXT_COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_command;
  logic [CHAR_W-1:0]   in_char_code;
  logic [INDEX_W-1:0]  in_cell_index;
  logic                out_valid;
  logic                out_ready;
  logic [CURSOR_W-1:0] out_cursor_pos;
  logic [CHAR_W-1:0]   out_cell_char;
  logic [ATTR_W-1:0]   out_cell_attr;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int fail_count;
  int outstanding;
  int sent_count = 0;
  int burst_left = 0;

  text_console_char_writer #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  console_checker #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_char  (out_cell_char),
    .out_cell_attr  (out_cell_attr),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if it hangs
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Offer one item, opening a new burst after a random gap when the last one is spent
  task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] code,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_char_code  <= code;
    in_cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_count++;
  endtask

  // Drop valid and wait until every result is in and the block has settled
  task automatic wait_idle();
    @(negedge clk);
    in_valid   <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_text_color(input logic [ATTR_W-1:0] colour);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TEXT_COLOR_ADDR;
    pwdata  <= APB_DW'(colour);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stall patterns, plus two long hold-offs mid-run
  initial begin
    int hold_left;
    int hold_marks;
    int mode_left;
    int stall_mode;
    hold_left  = 0;
    hold_marks = 0;
    mode_left  = 0;
    stall_mode = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_marks < 2 && sent_count >= 300 + 400 * hold_marks) begin
        hold_left = HOLD_CYCLES;
        hold_marks++;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    int                 phase;
    int                 k;
    int                 pick;
    logic               cmd;
    logic [CHAR_W-1:0]  code;
    logic [INDEX_W-1:0] idx;
    logic [ATTR_W-1:0]  colour;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_PUT;
    in_char_code  = '0;
    in_cell_index = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, under the reset colour
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_READ, 8'hFF, 11'd1999);
    send_item(CMD_READ, 8'h00, 11'd2000);   // out of range
    send_item(CMD_READ, 8'h00, 11'h7FF);
    send_item(CMD_PUT, 8'h41, 11'h7FF);
    send_item(CMD_PUT, SPACE_CODE, 11'd0);
    send_item(CMD_PUT, PRINT_HI, 11'd0);
    send_item(CMD_PUT, 8'h00, 11'd0);       // control codes without effect
    send_item(CMD_PUT, 8'h1F, 11'd0);
    send_item(CMD_PUT, 8'h80, 11'd0);       // high codes without effect
    send_item(CMD_PUT, 8'hFF, 11'd0);
    send_item(CMD_PUT, CODE_BS, 11'd0);
    send_item(CMD_PUT, CODE_CR, 11'd0);
    send_item(CMD_PUT, CODE_BS, 11'd0);     // backspace at the first cell
    send_item(CMD_PUT, CODE_TAB, 11'd0);
    send_item(CMD_PUT, CODE_TAB, 11'd0);    // tab from a tab stop
    send_item(CMD_PUT, CODE_LF, 11'd0);
    send_item(CMD_PUT, 8'h7E, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd0);
    send_item(CMD_READ, 8'h00, 11'd1);
    send_item(CMD_READ, 8'h00, 11'd2);
    send_item(CMD_READ, 8'h00, 11'd80);

    // Random phases, each under its own colour
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: colour = 8'h00;
        1: colour = 8'hFF;
        4: colour = RESET_ATTR;
        default: colour = ATTR_W'($urandom_range(1, 254));
      endcase
      write_text_color(colour);

      for (k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        pick = $urandom_range(0, 99);
        code = CHAR_W'($urandom_range(0, 255));
        idx  = INDEX_W'($urandom_range(0, 2047));
        if (pick < 30) begin
          // reads: half anywhere, half in the bottom rows where text lands
          cmd = CMD_READ;
          if ($urandom_range(0, 1) == 1)
            idx = INDEX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
        end else begin
          cmd  = CMD_PUT;
          pick = $urandom_range(0, 99);
          if (pick < 62)      code = CHAR_W'($urandom_range(PRINT_LO, PRINT_HI));
          else if (pick < 77) code = CODE_LF;
          else if (pick < 82) code = CODE_TAB;
          else if (pick < 87) code = CODE_BS;
          else if (pick < 90) code = CODE_CR;
          else if (pick < 95) code = CHAR_W'($urandom_range(0, PRINT_LO - 1));
          else                code = CHAR_W'($urandom_range(PRINT_HI + 1, 255));
        end
        send_item(cmd, code, idx);
      end
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
